[rtl/gctn_pkg.sv]
// package for the grid cell triangle normal block
// shared widths, register indexes and request payload types; no dependencies
package gctn_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ROWS    = 2'd1;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned MUL_W   = 31;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned QUO_W   = FRAC_W + 1;
  localparam int unsigned NUM_W   = ROOT_W + FRAC_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] top_left_x;
    logic signed [COORD_W-1:0] top_left_y;
    logic signed [COORD_W-1:0] top_left_z;
    logic signed [COORD_W-1:0] bottom_left_x;
    logic signed [COORD_W-1:0] bottom_left_y;
    logic signed [COORD_W-1:0] bottom_left_z;
    logic signed [COORD_W-1:0] bottom_right_x;
    logic signed [COORD_W-1:0] bottom_right_y;
    logic signed [COORD_W-1:0] bottom_right_z;
    logic signed [COORD_W-1:0] top_right_x;
    logic signed [COORD_W-1:0] top_right_y;
    logic signed [COORD_W-1:0] top_right_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [IDX_W-1:0]         first_vertex;
    logic [IDX_W-1:0]         second_vertex;
    logic [IDX_W-1:0]         third_vertex;
    logic [IDX_W-1:0]         face_number;
    logic                     last_of_cell;
  } out_item_t;

endpackage

[rtl/gctn_mul.sv]
// shared unsigned multiplier with registered product
// used for cross products, squared norms and vertex index; uses gctn_pkg
module gctn_mul (
  input  logic                          clk,
  input  logic [gctn_pkg::MUL_W-1:0]    a,
  input  logic [gctn_pkg::MUL_W-1:0]    b,
  output logic [gctn_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= gctn_pkg::PROD_W'(a) * gctn_pkg::PROD_W'(b);
  end

endmodule

[rtl/gctn_root.sv]
// iterative integer square root, two bits of the radicand per cycle
// depends on gctn_pkg for widths
module gctn_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gctn_pkg::SUM_W-1:0]    value,
  output logic                          busy,
  output logic                          done,
  output logic [gctn_pkg::ROOT_W-1:0]   root
);

  localparam int unsigned CW = $clog2(gctn_pkg::ROOT_W);

  logic [gctn_pkg::SUM_W-1:0] rem;
  logic [gctn_pkg::SUM_W-1:0] res;
  logic [gctn_pkg::SUM_W-1:0] bitv;
  logic [gctn_pkg::SUM_W-1:0] trial;
  logic [gctn_pkg::SUM_W-1:0] rem_next;
  logic [gctn_pkg::SUM_W-1:0] res_next;
  logic [CW-1:0]              cnt;

  always_comb begin
    trial = res + bitv;
    if (rem >= trial) begin
      rem_next = rem - trial;
      res_next = (res >> 1) + bitv;
    end else begin
      rem_next = rem;
      res_next = res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(gctn_pkg::ROOT_W - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= {2'b01, {(gctn_pkg::SUM_W - 2){1'b0}}};
    end else if (busy) begin
      rem  <= rem_next;
      res  <= res_next;
      bitv <= bitv >> 2;
    end
  end

  assign root = res[gctn_pkg::ROOT_W-1:0];

endmodule

[rtl/gctn_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W
// depends on gctn_pkg for widths
module gctn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gctn_pkg::NUM_W-1:0]    num,
  input  logic [gctn_pkg::ROOT_W-1:0]   den,
  output logic                          busy,
  output logic                          done,
  output logic [gctn_pkg::QUO_W-1:0]    quo
);

  localparam int unsigned CW = $clog2(gctn_pkg::QUO_W);

  logic [gctn_pkg::NUM_W-1:0] rem;
  logic [gctn_pkg::NUM_W-1:0] dsh;
  logic [CW-1:0]              cnt;
  logic                       ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(gctn_pkg::QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      // divisor aligned to the top quotient bit
      dsh <= {den, {gctn_pkg::FRAC_W{1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[gctn_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

[rtl/grid_cell_triangle_normals.sv]
// top level: sequencer, cell counters, datapath registers and output register
// depends on gctn_pkg, gctn_mul, gctn_root, gctn_div
//
//  channel  | signals                         | moves
//  ---------+---------------------------------+----------------------------------
//  input    | in_valid in_ready in_data       | one cell, four corners in Q16.16
//  output   | out_valid out_ready out_data    | one triangle per request, two/cell
//  config   | cfg_valid cfg_ready cfg_index   | register write, always ready
//           | cfg_data                        |
//
// a cell's time with both normals nonzero is dominated per triangle by the 32-step
// square root and three divides, plus cross products and squares on the one shared
// multiplier and a normal pre-shift that repeats until the normal fits the multiplier;
// a zero-length normal skips the three divides
// in_ready is high only while idle; a finished triangle waits in the output
// register and the next one waits for it to be taken
// rst is synchronous; counters and cell registers return to their reset values
module grid_cell_triangle_normals #(
  parameter int unsigned MAX_COLUMNS = gctn_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = gctn_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gctn_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gctn_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gctn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gctn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned XW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RLW = $clog2(MAX_ROWS + 1);
  localparam int unsigned WLW = CLW + 1;
  localparam int unsigned VW  = $clog2((MAX_ROWS + 1) * (MAX_COLUMNS + 1) + 1);
  localparam int unsigned EW  = gctn_pkg::COORD_W;
  localparam int unsigned NW  = 63;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IDX0   = 4'd1;
  localparam logic [3:0] S_IDX1   = 4'd2;
  localparam logic [3:0] S_EDGE   = 4'd3;
  localparam logic [3:0] S_EFIT   = 4'd4;
  localparam logic [3:0] S_CROSS  = 4'd5;
  localparam logic [3:0] S_NABS   = 4'd6;
  localparam logic [3:0] S_NFIT   = 4'd7;
  localparam logic [3:0] S_SQ     = 4'd8;
  localparam logic [3:0] S_RSTART = 4'd9;
  localparam logic [3:0] S_ROOT   = 4'd10;
  localparam logic [3:0] S_DSTART = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0]                        state;
  logic [2:0]                        step;
  logic [1:0]                        comp;
  logic                              tri_sel;
  logic [gctn_pkg::CFG_DATA_W-1:0]   cell_columns;
  logic [gctn_pkg::CFG_DATA_W-1:0]   cell_rows;
  logic [XW-1:0]                     column_count;
  logic [YW-1:0]                     row_count;
  logic [CLW-1:0]                    cols;
  logic [RLW-1:0]                    rows;
  logic [WLW-1:0]                    wid;
  gctn_pkg::in_item_t                item;
  logic [VW-1:0]                     top;
  logic [VW-1:0]                     cellno;
  logic [VW-1:0]                     bot;

  logic signed [EW-1:0]              ca [3];
  logic signed [EW-1:0]              cb [3];
  logic signed [EW-1:0]              cc [3];
  logic signed [EW:0]                dif [6];
  logic                              es [6];
  logic [EW-1:0]                     em [6];
  logic                              psgn;
  logic signed [63:0]                n [3];
  logic                              ns [3];
  logic [NW-1:0]                     nm [3];
  logic [NW-1:0]                     orm;
  logic [gctn_pkg::SUM_W-1:0]        sum;
  logic [gctn_pkg::ROOT_W-1:0]       r;
  logic signed [gctn_pkg::NORM_W-1:0] nq [3];

  logic [gctn_pkg::MUL_W-1:0]        mul_a;
  logic [gctn_pkg::MUL_W-1:0]        mul_b;
  logic [gctn_pkg::PROD_W-1:0]       mul_p;
  logic                              cross_sgn;
  logic signed [63:0]                sp;

  logic                              root_start;
  logic                              root_busy;
  logic                              root_done;
  logic [gctn_pkg::ROOT_W-1:0]       root_val;
  logic                              div_start;
  logic                              div_busy;
  logic                              div_done;
  logic [gctn_pkg::QUO_W-1:0]        div_q;
  logic [gctn_pkg::NUM_W-1:0]        div_num;
  logic                              out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // register values zero and above the maximum are clamped
  always_comb begin
    if (cell_columns == '0) begin
      cols = CLW'(1);
    end else if (32'(cell_columns) > 32'(MAX_COLUMNS)) begin
      cols = CLW'(MAX_COLUMNS);
    end else begin
      cols = CLW'(cell_columns);
    end
    if (cell_rows == '0) begin
      rows = RLW'(1);
    end else if (32'(cell_rows) > 32'(MAX_ROWS)) begin
      rows = RLW'(MAX_ROWS);
    end else begin
      rows = RLW'(cell_rows);
    end
  end

  assign wid = WLW'(cols) + WLW'(1);
  assign bot = top + VW'(wid);

  // corner choice per triangle
  always_comb begin
    if (!tri_sel) begin
      ca = '{item.top_left_x, item.top_left_y, item.top_left_z};
      cb = '{item.bottom_left_x, item.bottom_left_y, item.bottom_left_z};
      cc = '{item.bottom_right_x, item.bottom_right_y, item.bottom_right_z};
    end else begin
      ca = '{item.bottom_right_x, item.bottom_right_y, item.bottom_right_z};
      cb = '{item.top_right_x, item.top_right_y, item.top_right_z};
      cc = '{item.top_left_x, item.top_left_y, item.top_left_z};
    end
    for (int i = 0; i < 3; i++) begin
      dif[i]     = {cb[i][EW-1], cb[i]} - {ca[i][EW-1], ca[i]};
      dif[3 + i] = {cc[i][EW-1], cc[i]} - {ca[i][EW-1], ca[i]};
    end
  end

  assign orm = nm[0] | nm[1] | nm[2];

  // shared multiplier operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cross_sgn = 1'b0;
    case (state)
      S_IDX0: begin
        mul_a = gctn_pkg::MUL_W'(row_count);
        mul_b = gctn_pkg::MUL_W'(wid);
      end
      S_CROSS: begin
        case (step)
          3'd0: begin
            mul_a = em[4][gctn_pkg::MUL_W-1:0]; mul_b = em[2][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[4] ^ es[2];
          end
          3'd1: begin
            mul_a = em[5][gctn_pkg::MUL_W-1:0]; mul_b = em[1][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[5] ^ es[1];
          end
          3'd2: begin
            mul_a = em[5][gctn_pkg::MUL_W-1:0]; mul_b = em[0][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[5] ^ es[0];
          end
          3'd3: begin
            mul_a = em[3][gctn_pkg::MUL_W-1:0]; mul_b = em[2][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[3] ^ es[2];
          end
          3'd4: begin
            mul_a = em[3][gctn_pkg::MUL_W-1:0]; mul_b = em[1][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[3] ^ es[1];
          end
          3'd5: begin
            mul_a = em[4][gctn_pkg::MUL_W-1:0]; mul_b = em[0][gctn_pkg::MUL_W-1:0];
            cross_sgn = es[4] ^ es[0];
          end
          default: begin
            mul_a = '0;
          end
        endcase
      end
      S_SQ: begin
        case (step)
          3'd0: begin
            mul_a = nm[0][gctn_pkg::MUL_W-1:0]; mul_b = nm[0][gctn_pkg::MUL_W-1:0];
          end
          3'd1: begin
            mul_a = nm[1][gctn_pkg::MUL_W-1:0]; mul_b = nm[1][gctn_pkg::MUL_W-1:0];
          end
          3'd2: begin
            mul_a = nm[2][gctn_pkg::MUL_W-1:0]; mul_b = nm[2][gctn_pkg::MUL_W-1:0];
          end
          default: begin
            mul_a = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign sp = psgn ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});

  assign root_start = (state == S_RSTART);
  assign div_start  = (state == S_DSTART) && (r != '0);
  assign div_num    = gctn_pkg::NUM_W'({nm[comp][gctn_pkg::MUL_W-1:0],
                                         {gctn_pkg::FRAC_W{1'b0}}})
                    + gctn_pkg::NUM_W'(r[gctn_pkg::ROOT_W-1:1]);
  assign out_load   = (state == S_EMIT) && (!out_valid || out_ready);

  gctn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  gctn_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (sum),
    .busy  (root_busy),
    .done  (root_done),
    .root  (root_val)
  );

  gctn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      comp         <= '0;
      tri_sel      <= 1'b0;
      cell_columns <= gctn_pkg::CFG_DATA_W'(1);
      cell_rows    <= gctn_pkg::CFG_DATA_W'(1);
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state   <= S_IDX0;
            tri_sel <= 1'b0;
          end
        end
        S_IDX0: state <= S_IDX1;
        S_IDX1: state <= S_EDGE;
        S_EDGE: state <= S_EFIT;
        S_EFIT: begin
          state <= S_CROSS;
          step  <= '0;
        end
        S_CROSS: begin
          if (step == 3'd6) begin
            state <= S_NABS;
            step  <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_NABS: state <= S_NFIT;
        S_NFIT: begin
          if (orm[NW-1:gctn_pkg::MUL_W] == '0) begin
            state <= S_SQ;
            step  <= '0;
          end
        end
        S_SQ: begin
          if (step == 3'd3) begin
            state <= S_RSTART;
            step  <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_RSTART: state <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            state <= S_DSTART;
            comp  <= '0;
          end
        end
        S_DSTART: begin
          if (r != '0) begin
            state <= S_DIV;
          end else if (comp == 2'd2) begin
            state <= S_EMIT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (comp == 2'd2) begin
              state <= S_EMIT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DSTART;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (!tri_sel) begin
              tri_sel <= 1'b1;
              state   <= S_EDGE;
            end else begin
              state <= S_IDLE;
              if (CLW'(column_count) + CLW'(1) >= cols) begin
                column_count <= '0;
                if (RLW'(row_count) + RLW'(1) >= rows) begin
                  row_count <= '0;
                end else begin
                  row_count <= row_count + YW'(1);
                end
              end else begin
                column_count <= column_count + XW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid) begin
        if (cfg_index == gctn_pkg::REG_CELL_COLUMNS) begin
          cell_columns <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end else if (cfg_index == gctn_pkg::REG_CELL_ROWS) begin
          cell_rows    <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    case (state)
      S_IDX1: begin
        top    <= VW'(mul_p) + VW'(column_count);
        // y*cols + x = y*(cols+1) + x - y
        cellno <= VW'(mul_p) + VW'(column_count) - VW'(row_count);
      end
      S_EDGE: begin
        for (int i = 0; i < 6; i++) begin
          es[i] <= dif[i][EW];
          em[i] <= dif[i][EW] ? EW'(-dif[i]) : EW'(dif[i]);
        end
      end
      S_EFIT: begin
        // one halving is always enough for a 33-bit difference
        if (em[0][EW-1] | em[1][EW-1] | em[2][EW-1] |
            em[3][EW-1] | em[4][EW-1] | em[5][EW-1]) begin
          for (int i = 0; i < 6; i++) begin
            em[i] <= em[i] >> 1;
          end
        end
      end
      S_CROSS: begin
        psgn <= cross_sgn;
        case (step)
          3'd1: n[0] <= sp;
          3'd2: n[0] <= n[0] - sp;
          3'd3: n[1] <= sp;
          3'd4: n[1] <= n[1] - sp;
          3'd5: n[2] <= sp;
          3'd6: n[2] <= n[2] - sp;
          default: begin
          end
        endcase
      end
      S_NABS: begin
        for (int i = 0; i < 3; i++) begin
          ns[i] <= n[i][63];
          nm[i] <= n[i][63] ? NW'(-n[i]) : NW'(n[i]);
        end
      end
      S_NFIT: begin
        // a coarse step only when at least eight more bits must go
        if (orm[NW-1:38] != '0) begin
          for (int i = 0; i < 3; i++) begin
            nm[i] <= nm[i] >> 8;
          end
        end else if (orm[NW-1:gctn_pkg::MUL_W] != '0) begin
          for (int i = 0; i < 3; i++) begin
            nm[i] <= nm[i] >> 1;
          end
        end
        sum <= '0;
      end
      S_SQ: begin
        if (step != 3'd0) begin
          sum <= sum + gctn_pkg::SUM_W'(mul_p);
        end
      end
      S_ROOT: begin
        if (root_done) begin
          r <= root_val;
        end
      end
      S_DSTART: begin
        if (r == '0) begin
          nq[comp] <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          nq[comp] <= ns[comp] ? -$signed(gctn_pkg::NORM_W'(div_q))
                               : $signed(gctn_pkg::NORM_W'(div_q));
        end
      end
      default: begin
        sum <= sum;
      end
    endcase

    if (out_load) begin
      out_data.normal_x     <= nq[0];
      out_data.normal_y     <= nq[1];
      out_data.normal_z     <= nq[2];
      out_data.face_number  <= gctn_pkg::IDX_W'({cellno, tri_sel});
      out_data.last_of_cell <= tri_sel;
      if (!tri_sel) begin
        out_data.first_vertex  <= gctn_pkg::IDX_W'(top);
        out_data.second_vertex <= gctn_pkg::IDX_W'(bot);
        out_data.third_vertex  <= gctn_pkg::IDX_W'(bot + VW'(1));
      end else begin
        out_data.first_vertex  <= gctn_pkg::IDX_W'(bot + VW'(1));
        out_data.second_vertex <= gctn_pkg::IDX_W'(top + VW'(1));
        out_data.third_vertex  <= gctn_pkg::IDX_W'(top);
      end
    end
  end

  a_one_cell_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a cell is in flight");

  a_root_start_idle: assert property (@(posedge clk) disable iff (rst)
    root_start |-> !root_busy)
    else $error("square root restarted while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_column_in_grid: assert property (@(posedge clk) disable iff (rst)
    CLW'(column_count) < cols)
    else $error("column counter outside the grid");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
                   out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384))
    else $error("normal component out of unit range");

endmodule
